[sv/assert_macros.svh]
// Assertion macros for the RTL; conv_encode_interleave.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[sv/cei_pkg.sv]
// Package for the convolutional encoder and interleaver: code table and word functions.
package cei_pkg;

    localparam int BYTE_W = 8;
    localparam int HIST_W = 3;
    localparam int PAIR_W = 16;
    localparam int WORD_W = 32;

    // Two code bits per input bit, indexed by {history, bit}
    localparam logic [1:0] CODE_TABLE [16] = '{
        2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
        2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
    };

    // Encode one byte MSB first; first code lands in bits 15..14.
    function automatic logic [PAIR_W-1:0] cei_encode(
        input logic [BYTE_W-1:0] data,
        input logic [HIST_W-1:0] hist_in
    );
        logic [HIST_W-1:0] hist;
        logic [3:0]        idx;
        logic [PAIR_W-1:0] pair;
        hist = hist_in;
        pair = '0;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            idx  = {hist, data[k]};
            pair = {pair[PAIR_W-3:0], CODE_TABLE[idx]};
            hist = idx[HIST_W-1:0];
        end
        return pair;
    endfunction

    // 4x4 dibit interleave: top dibit j takes dibit j/4 of coded byte 3 - j%4.
    function automatic logic [WORD_W-1:0] cei_interleave(
        input logic [PAIR_W-1:0] first,
        input logic [PAIR_W-1:0] second
    );
        logic [7:0]        c [4];
        logic [WORD_W-1:0] word;
        c[0] = first[15:8];
        c[1] = first[7:0];
        c[2] = second[15:8];
        c[3] = second[7:0];
        word = '0;
        for (int j = 0; j < 16; j++) begin
            word[WORD_W-1-2*j -: 2] = c[2'(3 - (j & 3))][2*(j >> 2) +: 2];
        end
        return word;
    endfunction

endpackage

[sv/conv_encode_interleave.sv]
// Top level: rate-1/2 K=4 convolutional encoder with 4x4 dibit interleaver.
// Takes one packet byte per cycle and keeps that rate while the output side
// is not stalling; a word held in the result register under i_out_stall
// stalls the input as soon as the next byte needs a word slot. A byte is
// held in the input register, where the whole encode and interleave is done
// by short logic, and the finished word is then loaded into the result
// register, which drives o_out_valid; an output stall can keep the byte
// waiting in the input register. Two bytes make one 32-bit word; a packet
// with an odd byte count closes with a word interleaved from its last coded
// pair and a zero pair, with o_odd_length set. i_first_of_packet clears the
// encoder history and drops any half-built word.
`include "assert_macros.svh"

module conv_encode_interleave import cei_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_first_of_packet,
    input  logic              i_last_of_packet,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_coded_word,
    output logic              o_last_word,
    output logic              o_odd_length
);

    // input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_first;
    logic              r_s1_last;

    // encoder state
    logic [HIST_W-1:0] r_hist;
    logic [PAIR_W-1:0] r_held;
    logic              r_pending;

    // result register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_last;
    logic              r_out_odd;

    logic              in_accept;
    logic              out_free;
    logic              s1_emit;
    logic              s1_go;
    logic              pending_eff;
    logic [HIST_W-1:0] hist_eff;
    logic [PAIR_W-1:0] s1_pair;
    logic [WORD_W-1:0] n_word;
    logic              n_pending;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign pending_eff = r_pending && !r_s1_first;
    assign hist_eff    = r_s1_first ? '0 : r_hist;
    assign s1_pair     = cei_encode(r_s1_byte, hist_eff);
    assign s1_emit     = r_s1_valid && (pending_eff || r_s1_last);
    assign s1_go       = r_s1_valid && (!s1_emit || out_free);
    assign o_in_stall  = r_s1_valid && !s1_go;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign n_pending   = !pending_eff && !r_s1_last;

    always_comb begin
        if (pending_eff) begin
            n_word = cei_interleave(r_held, s1_pair);
        end else begin
            n_word = cei_interleave(s1_pair, '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte  <= i_data_byte;
            r_s1_first <= i_first_of_packet;
            r_s1_last  <= i_last_of_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist    <= '0;
            r_held    <= '0;
            r_pending <= 1'b0;
        end else if (s1_go) begin
            // history after a byte is just its three low bits
            r_hist    <= r_s1_byte[HIST_W-1:0];
            r_pending <= n_pending;
            r_held    <= n_pending ? s1_pair : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            r_out_word <= n_word;
            r_out_last <= r_s1_last;
            r_out_odd  <= !pending_eff;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_coded_word = r_out_word;
    assign o_last_word  = r_out_last;
    assign o_odd_length = r_out_odd;

    `ASSERT_CLK(a_odd_is_last, (r_out_valid && r_out_odd) |-> r_out_last, "odd word not last")
    `ASSERT_CLK(a_hold_sets_pending, (s1_go && !s1_emit) |=> r_pending, "pair not held")
    `ASSERT_CLK(a_emit_clears_pending, (s1_go && s1_emit) |=> !r_pending, "pair kept after word")
    `ASSERT_CLK(a_emit_fills_out, (s1_go && s1_emit) |=> r_out_valid, "word lost")
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_out_valid && !r_s1_valid && !r_pending), "reset")

endmodule
